[hdl/bcc_pkg.sv]
package bcc_pkg;

  localparam int BUFFER_DEPTH = 8;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int COUNT_W      = 8;
  localparam int TIME_W       = 16;
  localparam int CFG_ADDR_W   = 3;

  typedef logic [1:0] click_code_t;

  localparam click_code_t CODE_NONE   = 2'd0;
  localparam click_code_t CODE_NORMAL = 2'd1;
  localparam click_code_t CODE_DOUBLE = 2'd2;
  localparam click_code_t CODE_HOLD   = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_MODE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOUNCE_TIME   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_DOUBLE_WINDOW = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_START  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_PERIOD = 3'd4;

  typedef struct packed {
    logic              repeat_mode;
    logic [TIME_W-1:0] bounce_time;
    logic [TIME_W-1:0] double_window;
    logic [TIME_W-1:0] repeat_start;
    logic [TIME_W-1:0] repeat_period;
  } cfg_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    click_code_t code;
  } fifo_req_t;

  typedef struct packed {
    logic             hit;
    logic [PTR_W-1:0] count_nxt;
  } fifo_stat_t;

endpackage

[hdl/bcc_classify.sv]
module bcc_classify (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tick_en,
  input  logic                 pressed,
  input  bcc_pkg::cfg_t        cfg,
  output logic                 push,
  output bcc_pkg::click_code_t push_code
);
  import bcc_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT, PH_BOUNCE, PH_PREP, PH_WAITREP, PH_LOOPREP, PH_HELD
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [TIME_W-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [1:0]        presses_r, presses_nxt;

  // stopwatch saturates at all ones
  assign elapsed_inc = (elapsed_r == {TIME_W{1'b1}}) ? elapsed_r : elapsed_r + 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    presses_nxt = presses_r;
    push        = 1'b0;
    push_code   = CODE_NORMAL;
    if (tick_en) begin
      elapsed_nxt = elapsed_inc;
      if (pressed) begin
        case (phase_r)
          PH_WAIT: begin
            elapsed_nxt = '0;
            if (presses_r != 2'd2) presses_nxt = presses_r + 2'd1;
            phase_nxt = PH_BOUNCE;
          end
          PH_BOUNCE: begin
            if (elapsed_inc > cfg.bounce_time) phase_nxt = PH_PREP;
          end
          PH_PREP: begin
            if (elapsed_inc > cfg.double_window) begin
              push        = 1'b1;
              presses_nxt = 2'd0;
              if (cfg.repeat_mode) begin
                push_code = CODE_NORMAL;
                phase_nxt = PH_WAITREP;
              end else begin
                push_code = CODE_HOLD;
                phase_nxt = PH_HELD;
              end
            end
          end
          PH_WAITREP: begin
            if (elapsed_inc > cfg.repeat_start) phase_nxt = PH_LOOPREP;
          end
          PH_LOOPREP: begin
            if (elapsed_inc > cfg.repeat_period) begin
              push        = 1'b1;
              push_code   = CODE_NORMAL;
              elapsed_nxt = '0;
            end
          end
          default: begin
          end
        endcase
      end else begin
        if (presses_r != 2'd0 && elapsed_inc > cfg.double_window) begin
          push        = 1'b1;
          push_code   = (presses_r == 2'd1) ? CODE_NORMAL : CODE_DOUBLE;
          presses_nxt = 2'd0;
        end
        phase_nxt = PH_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      elapsed_r <= '0;
      presses_r <= 2'd0;
    end else begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      presses_r <= presses_nxt;
    end
  end

endmodule

[hdl/bcc_fifo.sv]
module bcc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bcc_pkg::fifo_req_t   req,
  output bcc_pkg::fifo_stat_t  stat,
  output bcc_pkg::click_code_t rd_data_r
);
  import bcc_pkg::*;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(BUFFER_DEPTH - 1);

  click_code_t      mem [BUFFER_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] count_r, count_nxt;
  logic             push_ok, pop_ok;

  // one slot stays free: a new code is dropped once DEPTH-1 are waiting
  assign push_ok = req.push && (count_r != LAST_SLOT);
  assign pop_ok  = req.pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
      count_nxt  = count_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
      count_nxt  = count_r - 1'b1;
    end
  end

  assign stat.hit       = pop_ok;
  assign stat.count_nxt = count_nxt;

  // a pop only reaches entries written by earlier items, so the registered
  // read never races a write to the same slot
  always_ff @(posedge clk) begin
    if (push_ok) mem[wr_ptr_r] <= req.code;
    if (pop_ok) rd_data_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST_SLOT)
    else $error("ring buffer over its capacity");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.push && req.pop))
    else $error("tick and read in the same cycle");

  a_empty_pop_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (req.pop && count_r == '0) |=> (count_r == '0 && $stable(rd_ptr_r)))
    else $error("read of empty buffer moved state");

  a_ptr_span: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("pointers disagree with empty count");

endmodule

[hdl/button_click_classifier.sv]
// Button click classifier. Each input item is either a one-millisecond tick
// carrying the sampled button level (in_tuser = 0, in_tdata[0] = pressed) or
// a read of the oldest click code (in_tuser = 1). One item is taken every
// clock cycle unless the output is stalled; each gives exactly one result,
// which appears in the cycle after acceptance, as the click memory has a
// registered read port. A single output register holds the result; while it is stalled
// the input is held off. Configuration writes go through cfg_* and must be
// made while no item is in flight. The buffer holds BUFFER_DEPTH-1 codes;
// further clicks are dropped until a read frees a slot. No clearing pass is
// needed after reset.
module button_click_classifier (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,  // [0] button_pressed
  input  logic                            in_tuser,  // [0] cmd
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] click_code, [9:2] waiting_count, [11:10] last_read_code
  output logic [15:0]                     out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bcc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bcc_pkg::TIME_W-1:0]      cfg_data
);
  import bcc_pkg::*;

  cfg_t             cfg_r;
  logic             in_acc, tick_en;
  logic             push;
  click_code_t      push_code;
  fifo_req_t        req;
  fifo_stat_t       stat;
  click_code_t      rd_data_r;

  logic             out_valid_r;
  logic             is_read_r;
  logic             hit_r;
  logic [PTR_W-1:0] count_r;
  click_code_t      last_code_r;
  click_code_t      res_code, res_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_mode   <= 1'b0;
      cfg_r.bounce_time   <= 16'd25;
      cfg_r.double_window <= 16'd300;
      cfg_r.repeat_start  <= 16'd800;
      cfg_r.repeat_period <= 16'd100;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_REPEAT_MODE:   cfg_r.repeat_mode   <= cfg_data[0];
        CFG_BOUNCE_TIME:   cfg_r.bounce_time   <= cfg_data;
        CFG_DOUBLE_WINDOW: cfg_r.double_window <= cfg_data;
        CFG_REPEAT_START:  cfg_r.repeat_start  <= cfg_data;
        CFG_REPEAT_PERIOD: cfg_r.repeat_period <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign tick_en   = in_acc && !in_tuser;

  bcc_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_en   (tick_en),
    .pressed   (in_tdata[0]),
    .cfg       (cfg_r),
    .push      (push),
    .push_code (push_code)
  );

  assign req.push = push;
  assign req.pop  = in_acc && in_tuser;
  assign req.code = push_code;

  bcc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .stat      (stat),
    .rd_data_r (rd_data_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_code_r <= CODE_NONE;
    end else begin
      // last code moves on as each result leaves, so the next one sees it
      if (out_valid_r && out_tready) last_code_r <= res_last;
      if (in_acc) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      is_read_r <= in_tuser;
      hit_r     <= stat.hit;
      count_r   <= stat.count_nxt;
    end
  end

  assign res_code = hit_r ? rd_data_r : CODE_NONE;
  assign res_last = is_read_r ? res_code : last_code_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_last, COUNT_W'(count_r), res_code};

endmodule
